### rtl/core/cteg_pkg.sv
package cteg_pkg;

  // Character number before reduction modulo the character count
  localparam int CH_W   = 15;
  localparam int SIDE_W = 4;

  localparam logic [3:0] OP_RDBYTE = 4'd0;
  localparam logic [3:0] OP_WRBYTE = 4'd1;
  localparam logic [3:0] OP_GETPEN = 4'd2;
  localparam logic [3:0] OP_SETPEN = 4'd3;
  localparam logic [3:0] OP_INVERT = 4'd4;
  localparam logic [3:0] OP_CLEAR  = 4'd5;
  localparam logic [3:0] OP_FLIPH  = 4'd6;
  localparam logic [3:0] OP_FLIPV  = 4'd7;
  localparam logic [3:0] OP_ROTATE = 4'd8;
  localparam logic [3:0] OP_SHL    = 4'd9;
  localparam logic [3:0] OP_SHR    = 4'd10;
  localparam logic [3:0] OP_SHU    = 4'd11;
  localparam logic [3:0] OP_SHD    = 4'd12;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_STRIDE = 2'd3;

  typedef enum logic [1:0] {
    CL_NONE,
    CL_BYTE,
    CL_PIXEL,
    CL_TILE
  } cls_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ADDR_A,
    S_ADDR_B,
    S_ADDR_C,
    S_RED,
    S_BYTE,
    S_BYTE_WAIT,
    S_PIX_RD,
    S_PIX_WAIT,
    S_G_RD,
    S_G_WAIT,
    S_S_RD,
    S_S_WAIT,
    S_S_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              multicolor;
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic [7:0]        stride;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic clear_wr;
    logic addr_a;
    logic addr_b;
    logic addr_c;
    logic load_ba;
    logic red_step;
    logic set_err;
    logic byte_wr;
    logic byte_cap;
    logic pix_eval;
    logic g_wr;
    logic walk_step;
    logic walk_clr;
    logic to_scatter;
    logic k_clr;
    logic k_step;
    logic s_cap;
    logic s_wr;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    cls_t cls;
    logic rot_bad;
    logic is_rd;
    logic red_last;
    logic clr_last;
    logic scatter;
    logic r_last;
    logic char_last;
    logic k_last;
  } sts_t;

endpackage

### rtl/core/cteg_ram.sv
module cteg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/cteg_regs.sv
module cteg_regs import cteg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.multicolor <= 1'b0;
      cfg.width      <= SIDE_W'(1);
      cfg.height     <= SIDE_W'(1);
      cfg.stride     <= 8'd1;
    end else if (wr) begin
      case (idx)
        REG_MODE:   cfg.multicolor <= pwdata[0];
        REG_WIDTH:  cfg.width      <= pwdata[SIDE_W-1:0];
        REG_HEIGHT: cfg.height     <= pwdata[SIDE_W-1:0];
        REG_STRIDE: cfg.stride     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:   prdata = {31'd0, cfg.multicolor};
      REG_WIDTH:  prdata = {{(32-SIDE_W){1'b0}}, cfg.width};
      REG_HEIGHT: prdata = {{(32-SIDE_W){1'b0}}, cfg.height};
      REG_STRIDE: prdata = {24'd0, cfg.stride};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

### rtl/core/cteg_ctrl.sv
module cteg_ctrl import cteg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        ctl.clear_wr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.cls)
          CL_BYTE: begin
            ctl.load_ba = 1'b1;
            state_next  = S_RED;
          end
          CL_PIXEL: state_next = S_ADDR_A;
          CL_TILE: begin
            if (sts.rot_bad) begin
              ctl.set_err = 1'b1;
              state_next  = S_FINISH;
            end else begin
              ctl.walk_clr = 1'b1;
              state_next   = S_ADDR_A;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_ADDR_A: begin
        ctl.addr_a = 1'b1;
        state_next = S_ADDR_B;
      end
      S_ADDR_B: begin
        ctl.addr_b = 1'b1;
        state_next = S_ADDR_C;
      end
      S_ADDR_C: begin
        ctl.addr_c = 1'b1;
        state_next = S_RED;
      end
      S_RED: begin
        ctl.red_step = 1'b1;
        if (sts.red_last) begin
          case (sts.cls)
            CL_BYTE:  state_next = S_BYTE;
            CL_PIXEL: state_next = S_PIX_RD;
            CL_TILE: begin
              if (sts.scatter) begin
                ctl.k_clr  = 1'b1;
                state_next = S_S_RD;
              end else begin
                state_next = S_G_RD;
              end
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_BYTE: begin
        if (sts.is_rd) begin
          state_next = S_BYTE_WAIT;
        end else begin
          ctl.byte_wr = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_BYTE_WAIT: begin
        ctl.byte_cap = 1'b1;
        state_next   = S_FINISH;
      end
      S_PIX_RD: state_next = S_PIX_WAIT;
      S_PIX_WAIT: begin
        ctl.pix_eval = 1'b1;
        state_next   = S_FINISH;
      end
      S_G_RD: state_next = S_G_WAIT;
      S_G_WAIT: begin
        ctl.g_wr      = 1'b1;
        ctl.walk_step = 1'b1;
        if (sts.r_last && sts.char_last) begin
          ctl.walk_clr   = 1'b1;
          ctl.to_scatter = 1'b1;
          state_next     = S_ADDR_A;
        end else if (sts.r_last) begin
          state_next = S_ADDR_A;
        end else begin
          state_next = S_G_RD;
        end
      end
      S_S_RD: state_next = S_S_WAIT;
      S_S_WAIT: begin
        ctl.s_cap  = 1'b1;
        ctl.k_step = 1'b1;
        state_next = sts.k_last ? S_S_WR : S_S_RD;
      end
      S_S_WR: begin
        ctl.s_wr      = 1'b1;
        ctl.walk_step = 1'b1;
        ctl.k_clr     = 1'b1;
        if (sts.r_last && sts.char_last) begin
          state_next = S_FINISH;
        end else if (sts.r_last) begin
          state_next = S_ADDR_A;
        end else begin
          state_next = S_S_RD;
        end
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // one word in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("new word taken while one is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten before it was taken");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !rsp_valid && !cmd_ready)
    else $error("activity during the clearing pass");

endmodule

### rtl/core/cteg_dp.sv
module cteg_dp import cteg_pkg::*; #(
  parameter int CHAR_COUNT    = 256,
  parameter int MAX_TILE_SIDE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  output sts_t        sts,
  input  cfg_t        cfg,
  input  logic [3:0]  operation,
  input  logic [7:0]  tile_index,
  input  logic [5:0]  pixel_x,
  input  logic [5:0]  pixel_y,
  input  logic [1:0]  pen_in,
  input  logic [10:0] byte_address,
  input  logic [7:0]  byte_data,
  output logic [7:0]  read_byte,
  output logic [1:0]  pen_out,
  output logic        byte_changed,
  output logic        not_square_error
);

  localparam int ST_DEPTH  = CHAR_COUNT * 8;
  localparam int AW        = $clog2(ST_DEPTH);
  localparam int CW        = AW - 3;
  localparam int CC_W      = $clog2(CHAR_COUNT + 1);
  // reduction: quotient estimate, then subtract
  localparam int RED_N     = 2;
  localparam int RI_W      = 1;
  localparam int Q_SH      = CH_W + CC_W;
  localparam int RC_W      = CH_W + 2;
  localparam int Q_W       = CH_W - CC_W + 1;
  localparam logic [RC_W-1:0] RECIP =
    RC_W'(((64'd1 << Q_SH) + 64'(CHAR_COUNT - 1)) / 64'(CHAR_COUNT));
  localparam int CX_W      = (MAX_TILE_SIDE > 1) ? $clog2(MAX_TILE_SIDE) : 1;
  localparam int R_W       = CX_W + 3;
  localparam int BW        = R_W + CX_W;
  localparam int BUF_DEPTH = 1 << BW;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] mx;
    mx = SIDE_W'(MAX_TILE_SIDE);
    if (v == '0) return SIDE_W'(1);
    if (v > mx) return mx;
    return v;
  endfunction

  // latched word
  logic [3:0]  op_q;
  logic [7:0]  tile_q;
  logic [5:0]  px_q;
  logic [5:0]  py_q;
  logic [1:0]  pen_q;
  logic [10:0] ba_q;
  logic [7:0]  bd_q;

  logic [SIDE_W-1:0] w;
  logic [SIDE_W-1:0] h;
  logic [7:0]        s;
  logic [CX_W-1:0]   wm1;
  logic [R_W-1:0]    hm1r;
  cls_t              cls;

  // character address pipeline
  logic [5:0]      idx_q;
  logic [11:0]     tw_q;
  logic [13:0]     prod_q;
  logic [13:0]     tf_q;
  logic [CH_W-1:0] ch_q;
  logic [RI_W-1:0] ri;
  logic [2:0]      cx_sel;
  logic [2:0]      cy_sel;
  logic [6:0]      cyw;
  logic [11:0]     tw_mul;
  logic [13:0]     prod_mul;
  logic [15:0]     tf_mul;
  logic [CH_W+RC_W-1:0] q_prod;
  logic [Q_W-1:0]  q_q;
  logic [CH_W-1:0] qc_mul;
  logic [CW-1:0]   chmod;
  logic [2:0]      row_sel;

  // tile walk
  logic [2:0]      r;
  logic [CX_W-1:0] cx;
  logic [CX_W-1:0] cy;
  logic [R_W-1:0]  rr;
  logic [2:0]      k;
  logic            scatter;

  logic [AW-1:0] clr_cnt;

  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [7:0]    st_wdata;
  logic [AW-1:0] st_raddr;
  logic [7:0]    st_rdata;

  logic [BW-1:0] buf_waddr;
  logic [BW-1:0] buf_raddr;
  logic [7:0]    buf_rdata;
  logic [R_W-1:0]  src_row;
  logic [CX_W-1:0] src_col;

  // pen logic
  logic [2:0] b;
  logic [2:0] sh;
  logic [7:0] m;
  logic [1:0] p;
  logic [1:0] pen_rd;
  logic [7:0] nv;
  logic       changed;
  logic       pix_we;

  logic [7:0] d0;
  logic [7:0] d1;
  logic [7:0] acc;
  logic [7:0] rev;
  logic [7:0] sbyte;

  logic [7:0] res_byte;
  logic [1:0] res_pen;
  logic       res_chg;
  logic       res_err;

  assign w    = clamp_side(cfg.width);
  assign h    = clamp_side(cfg.height);
  assign s    = (cfg.stride == 8'd0) ? 8'd1 : cfg.stride;
  assign wm1  = CX_W'(w - SIDE_W'(1));
  assign hm1r = {CX_W'(h - SIDE_W'(1)), 3'b111};
  assign rr   = {cy, r};

  always_comb begin
    case (op_q)
      OP_RDBYTE, OP_WRBYTE: cls = CL_BYTE;
      OP_GETPEN, OP_SETPEN: cls = CL_PIXEL;
      OP_INVERT, OP_CLEAR, OP_FLIPH, OP_FLIPV, OP_ROTATE,
      OP_SHL, OP_SHR, OP_SHU, OP_SHD: cls = CL_TILE;
      default: cls = CL_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      op_q   <= operation;
      tile_q <= tile_index;
      px_q   <= pixel_x;
      py_q   <= pixel_y;
      pen_q  <= pen_in;
      ba_q   <= byte_address;
      bd_q   <= byte_data;
    end
  end

  // character number = first + (cx + cy*w)*stride, reduced modulo CHAR_COUNT
  assign cx_sel   = (cls == CL_PIXEL) ? px_q[5:3] : 3'(cx);
  assign cy_sel   = (cls == CL_PIXEL) ? py_q[5:3] : 3'(cy);
  assign cyw      = cy_sel * w;
  assign tw_mul   = tile_q * w;
  assign prod_mul = idx_q * s;
  assign tf_mul   = tw_q * h;
  // rounded-up reciprocal gives the exact quotient for any CH_W-bit number
  assign q_prod   = ch_q * RECIP;
  assign qc_mul   = CH_W'(q_q) * CH_W'(CHAR_COUNT);
  assign chmod    = ch_q[CW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.addr_a) begin
      idx_q <= 6'(7'(cx_sel) + cyw);
      tw_q  <= tw_mul;
    end
    if (ctl.addr_b) begin
      prod_q <= prod_mul;
      tf_q   <= 14'(tf_mul);
    end
    if (ctl.addr_c) begin
      ch_q <= ((s == 8'd1) ? CH_W'(tf_q) : CH_W'(tile_q)) + CH_W'(prod_q);
      ri   <= RI_W'(RED_N - 1);
    end else if (ctl.load_ba) begin
      ch_q <= CH_W'(ba_q[10:3]);
      ri   <= RI_W'(RED_N - 1);
    end else if (ctl.red_step) begin
      if (ri != '0) begin
        q_q <= Q_W'(q_prod >> Q_SH);
      end else begin
        ch_q <= ch_q - qc_mul;
      end
      ri <= ri - 1'b1;
    end
  end

  always_comb begin
    case (cls)
      CL_BYTE:  row_sel = ba_q[2:0];
      CL_PIXEL: row_sel = py_q[2:0];
      default:  row_sel = r;
    endcase
  end

  // walk counters: cy outer, cx, then pixel row
  always_ff @(posedge clk) begin
    if (ctl.walk_clr) begin
      r  <= '0;
      cx <= '0;
      cy <= '0;
    end else if (ctl.walk_step) begin
      r <= r + 1'b1;
      if (r == 3'd7) begin
        if (cx == wm1) begin
          cx <= '0;
          cy <= cy + 1'b1;
        end else begin
          cx <= cx + 1'b1;
        end
      end
    end
    if (ctl.k_clr) begin
      k <= '0;
    end else if (ctl.k_step) begin
      k <= k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      scatter <= 1'b0;
    end else begin
      if (ctl.clear_wr) clr_cnt <= clr_cnt + 1'b1;
      if (ctl.latch) begin
        scatter <= 1'b0;
      end else if (ctl.to_scatter) begin
        scatter <= 1'b1;
      end
    end
  end

  // pen access
  assign b      = px_q[2:0];
  assign sh     = cfg.multicolor ? ((3'd7 - b) & 3'd6) : (3'd7 - b);
  assign m      = cfg.multicolor ? (8'd3 << sh) : (8'd1 << sh);
  assign p      = cfg.multicolor ? pen_q : {1'b0, pen_q[0]};
  assign pen_rd = 2'((st_rdata & m) >> sh);
  assign nv     = (st_rdata & ~m) | (8'(p) << sh);
  assign changed = (nv != st_rdata);
  assign pix_we  = ctl.pix_eval && (op_q == OP_SETPEN) && changed;

  // where each output byte of the tile comes from
  always_comb begin
    src_row = rr;
    src_col = cx;
    case (op_q)
      OP_FLIPH: src_col = wm1 - cx;
      OP_FLIPV: src_row = hm1r - rr;
      OP_SHU:   src_row = (rr == hm1r) ? '0 : rr + 1'b1;
      OP_SHD:   src_row = (rr == '0) ? hm1r : rr - 1'b1;
      OP_SHL: begin
        if (k == 3'd1) src_col = (cx == wm1) ? '0 : cx + 1'b1;
      end
      OP_SHR: begin
        if (k == 3'd1) src_col = (cx == '0) ? wm1 : cx - 1'b1;
      end
      OP_ROTATE: begin
        // bit k of the new byte sits in old row W-1-x, column byte cy
        src_row = {wm1 - cx, ~k};
        src_col = cy;
      end
      default: ;
    endcase
  end

  assign buf_raddr = {src_row, src_col};
  assign buf_waddr = {rr, cx};

  always_ff @(posedge clk) begin
    if (ctl.s_cap) begin
      if (k == 3'd0) d0 <= buf_rdata;
      if (k == 3'd1) d1 <= buf_rdata;
      acc <= {acc[6:0], buf_rdata[~r]};
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rev[i] = d0[7-i];
    end
  end

  always_comb begin
    case (op_q)
      OP_INVERT: sbyte = ~d0;
      OP_CLEAR:  sbyte = 8'd0;
      OP_FLIPH:  sbyte = rev;
      OP_SHL:    sbyte = {d0[6:0], d1[7]};
      OP_SHR:    sbyte = {d1[0], d0[7:1]};
      OP_ROTATE: sbyte = acc;
      default:   sbyte = d0;
    endcase
  end

  assign st_raddr = {chmod, row_sel};
  assign st_we    = ctl.clear_wr || ctl.byte_wr || pix_we || ctl.s_wr;
  assign st_waddr = ctl.clear_wr ? clr_cnt : {chmod, row_sel};

  always_comb begin
    if (ctl.clear_wr) begin
      st_wdata = 8'd0;
    end else if (ctl.byte_wr) begin
      st_wdata = bd_q;
    end else if (ctl.s_wr) begin
      st_wdata = sbyte;
    end else begin
      st_wdata = nv;
    end
  end

  cteg_ram #(
    .WIDTH (8),
    .DEPTH (ST_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  cteg_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_tbuf (
    .clk   (clk),
    .we    (ctl.g_wr),
    .waddr (buf_waddr),
    .wdata (st_rdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      res_byte <= 8'd0;
      res_pen  <= 2'd0;
      res_chg  <= 1'b0;
      res_err  <= 1'b0;
    end else begin
      if (ctl.set_err) res_err <= 1'b1;
      if (ctl.byte_cap) res_byte <= st_rdata;
      if (ctl.pix_eval && op_q == OP_GETPEN) res_pen <= pen_rd;
      if (pix_we) res_chg <= 1'b1;
    end
    if (ctl.out_load) begin
      read_byte        <= res_byte;
      pen_out          <= res_pen;
      byte_changed     <= res_chg;
      not_square_error <= res_err;
    end
  end

  assign sts.cls       = cls;
  assign sts.rot_bad   = (op_q == OP_ROTATE) && (w != h);
  assign sts.is_rd     = (op_q == OP_RDBYTE);
  assign sts.red_last  = (ri == '0);
  assign sts.clr_last  = (clr_cnt == AW'(ST_DEPTH - 1));
  assign sts.scatter   = scatter;
  assign sts.r_last    = (r == 3'd7);
  assign sts.char_last = (cx == wm1) && (cy == CX_W'(h - SIDE_W'(1)));

  always_comb begin
    case (op_q)
      OP_ROTATE:      sts.k_last = (k == 3'd7);
      OP_SHL, OP_SHR: sts.k_last = (k == 3'd1);
      default:        sts.k_last = (k == 3'd0);
    endcase
  end

  a_reduced: assert property (@(posedge clk) disable iff (rst)
    ctl.red_step && ri == '0 |=> {1'b0, ch_q} < 16'(CHAR_COUNT))
    else $error("character number not reduced below the character count");

  a_phase: assert property (@(posedge clk) disable iff (rst)
    (ctl.g_wr |-> !scatter) and (ctl.s_wr |-> scatter))
    else $error("tile buffer written back before the gather finished");

  a_square_rotate: assert property (@(posedge clk) disable iff (rst)
    ctl.s_wr && op_q == OP_ROTATE |-> w == h)
    else $error("rotate wrote back a tile that is not square");

endmodule

### rtl/core/charset_tile_edit_engine_core.sv
// Character-set tile editor. Holds CHAR_COUNT 8x8 one-bit characters (8 bytes
// each) and applies byte, pen and whole-tile commands to them.
// Command channel: cmd_valid/cmd_ready with operation and its operands.
// Result channel: rsp_valid/rsp_ready, one word for every command.
// Configuration: APB registers mode, tile width, tile height, stride.
// One command is worked at a time; every pen and tile character address goes
// through a two-multiply address pipeline, and every character number through
// a reciprocal modulo CHAR_COUNT reduction (quotient estimate, then subtract).
// Whole-tile commands gather the tile into a buffer, then write it back. The
// next command is taken the cycle after the current one has posted its result.
// Reset clears the store in a pass over all CHAR_COUNT*8 bytes; no command is
// taken until it ends. If the receiver stalls, the result waits in the
// output register and a following command stops just before posting.
module charset_tile_edit_engine_core import cteg_pkg::*; #(
  parameter int CHAR_COUNT    = 256,
  parameter int MAX_TILE_SIDE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  logic [3:0]  operation,
  input  logic [7:0]  tile_index,
  input  logic [5:0]  pixel_x,
  input  logic [5:0]  pixel_y,
  input  logic [1:0]  pen_in,
  input  logic [10:0] byte_address,
  input  logic [7:0]  byte_data,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [7:0]  read_byte,
  output logic [1:0]  pen_out,
  output logic        byte_changed,
  output logic        not_square_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  ctl_t ctl;
  sts_t sts;

  cteg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cteg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  cteg_dp #(
    .CHAR_COUNT    (CHAR_COUNT),
    .MAX_TILE_SIDE (MAX_TILE_SIDE)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .sts              (sts),
    .cfg              (cfg),
    .operation        (operation),
    .tile_index       (tile_index),
    .pixel_x          (pixel_x),
    .pixel_y          (pixel_y),
    .pen_in           (pen_in),
    .byte_address     (byte_address),
    .byte_data        (byte_data),
    .read_byte        (read_byte),
    .pen_out          (pen_out),
    .byte_changed     (byte_changed),
    .not_square_error (not_square_error)
  );

endmodule
